FILE: hdl/cpot_pkg.sv
// ----------------------------------------------------------------------------
// cpot_pkg
// Shared item types, sequencer states and control structs for the convex
// polygon overlap test.
// ----------------------------------------------------------------------------
package cpot_pkg;

  // Width of each coordinate field as it arrives on the input channel.
  localparam int VERTEX_FIELD_W = 16;

  typedef struct packed {
    logic                             polygon_select;
    logic signed [VERTEX_FIELD_W-1:0] vertex_x;
    logic signed [VERTEX_FIELD_W-1:0] vertex_y;
    logic                             end_of_pair;
  } in_item_t;

  typedef struct packed {
    logic collide;
    logic load_error;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_EDGE_A,
    S_EDGE_B,
    S_EDGE_C,
    S_PROJ,
    S_DRAIN,
    S_FINISH
  } state_t;

  // Sequencer to projection unit.
  typedef struct packed {
    logic side;       // polygon whose edge gives the current axis
    logic cap_vi;     // capture the edge start vertex from the read data
    logic load_axis;  // form the edge normal from the edge end vertex
    logic issue;      // a projection read was issued this cycle
    logic in_first;   // the issued index holds a vertex of the first polygon
    logic in_second;  // the issued index holds a vertex of the second polygon
    logic first_idx;  // the issued index is zero, so it opens the interval
  } proj_ctrl_t;

  // Projection unit back to the sequencer.
  typedef struct packed {
    logic busy;  // projections still in flight
    logic gap;   // the two intervals on the current axis are disjoint
  } proj_stat_t;

endpackage

FILE: hdl/cpot_ram.sv
// ----------------------------------------------------------------------------
// cpot_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cpot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cpot_proj.sv
// ----------------------------------------------------------------------------
// cpot_proj
// Axis formation and projection pipeline: multiply, sum, then min/max.
// ----------------------------------------------------------------------------
module cpot_proj #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpot_pkg::proj_ctrl_t      ctrl,
  input  logic [2*COORD_BITS-1:0]   rdata_first,
  input  logic [2*COORD_BITS-1:0]   rdata_second,
  output cpot_pkg::proj_stat_t      stat
);
  import cpot_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int AXW = CW + 1;
  localparam int PW  = CW + AXW;
  localparam int DW  = PW + 1;
  localparam int VW  = 2 * CW;

  logic [VW-1:0]         ev;
  logic signed [CW-1:0]  ev_x, ev_y;
  logic signed [CW-1:0]  x1, y1, x2, y2;

  logic signed [CW-1:0]  vi_x_r, vi_y_r;
  logic signed [AXW-1:0] ax_r, ay_r;

  logic s1_v_r, s1_in1_r, s1_in2_r, s1_first_r;
  logic s2_v_r, s2_in1_r, s2_in2_r, s2_first_r;

  logic signed [PW-1:0]  m1x_r, m1y_r, m2x_r, m2y_r;
  logic signed [DW-1:0]  d1, d2;
  logic signed [DW-1:0]  lo1_r, hi1_r, lo2_r, hi2_r;

  assign ev   = ctrl.side ? rdata_second : rdata_first;
  assign ev_x = signed'(ev[CW-1:0]);
  assign ev_y = signed'(ev[VW-1:CW]);

  assign x1 = signed'(rdata_first[CW-1:0]);
  assign y1 = signed'(rdata_first[VW-1:CW]);
  assign x2 = signed'(rdata_second[CW-1:0]);
  assign y2 = signed'(rdata_second[VW-1:CW]);

  assign d1 = DW'(m1x_r) + DW'(m1y_r);
  assign d2 = DW'(m2x_r) + DW'(m2y_r);

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= ctrl.issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap_vi) begin
      vi_x_r <= ev_x;
      vi_y_r <= ev_y;
    end
    // The normal of edge (vi -> vj) is (-(yj - yi), xj - xi).
    if (ctrl.load_axis) begin
      ax_r <= AXW'(vi_y_r) - AXW'(ev_y);
      ay_r <= AXW'(ev_x) - AXW'(vi_x_r);
    end

    s1_in1_r   <= ctrl.in_first;
    s1_in2_r   <= ctrl.in_second;
    s1_first_r <= ctrl.first_idx;

    s2_in1_r   <= s1_in1_r;
    s2_in2_r   <= s1_in2_r;
    s2_first_r <= s1_first_r;

    if (s1_v_r) begin
      m1x_r <= PW'(x1) * PW'(ax_r);
      m1y_r <= PW'(y1) * PW'(ay_r);
      m2x_r <= PW'(x2) * PW'(ax_r);
      m2y_r <= PW'(y2) * PW'(ay_r);
    end

    if (s2_v_r && s2_in1_r) begin
      if (s2_first_r || (d1 < lo1_r)) begin
        lo1_r <= d1;
      end
      if (s2_first_r || (d1 > hi1_r)) begin
        hi1_r <= d1;
      end
    end
    if (s2_v_r && s2_in2_r) begin
      if (s2_first_r || (d2 < lo2_r)) begin
        lo2_r <= d2;
      end
      if (s2_first_r || (d2 > hi2_r)) begin
        hi2_r <= d2;
      end
    end
  end

  assign stat.busy = s1_v_r || s2_v_r;
  assign stat.gap  = (hi1_r < lo2_r) || (hi2_r < lo1_r);

endmodule

FILE: hdl/convex_polygon_overlap_test_core.sv
// ----------------------------------------------------------------------------
// convex_polygon_overlap_test_core
// Separating axis overlap test for two convex polygons held in vertex RAMs.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | cpot_pkg::in_item_t (one vertex)
//   out_    | output    | out_valid/out_stall| cpot_pkg::out_item_t (one result)
//
// A vertex item without end_of_pair is written to its RAM and the block stays
// ready for the next. The item that ends the pair runs the test, or on a load
// error skips it, and S_FINISH hands the result over. On each of up to n1 + n2
// axes, S_EDGE_A to S_EDGE_C fetch the edge, S_PROJ reads once per vertex index
// up to max(n1, n2) and S_DRAIN drains the multiply-sum pipeline and compares.
// The single read port of each vertex RAM sets the pace of the projections.
// Reset clears the counts, the sequencer and the output valid; the RAMs are
// not cleared. A stalled result holds while further vertices are loaded.
// ----------------------------------------------------------------------------
module convex_polygon_overlap_test_core #(
  parameter int MAX_CORNERS = 8,
  parameter int COORD_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cpot_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpot_pkg::out_item_t  out_data
);
  import cpot_pkg::*;

  localparam int IW  = $clog2(MAX_CORNERS);
  localparam int CNW = $clog2(MAX_CORNERS + 1);
  localparam int CW  = COORD_BITS;
  localparam int VW  = 2 * CW;

  // Sequencer and load state.
  state_t          state_r, state_nxt;
  logic [CNW-1:0]  cnt1_r, cnt1_nxt;
  logic [CNW-1:0]  cnt2_r, cnt2_nxt;
  logic            ovf_r, ovf_nxt;
  logic            side_r, side_nxt;
  logic [IW-1:0]   edge_r, edge_nxt;
  logic [IW-1:0]   k_r, k_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // Load path.
  logic            acc;
  logic            full1, full2;
  logic            we1, we2;
  logic [CNW-1:0]  cnt1_ld, cnt2_ld;
  logic            ovf_ld;
  logic            load_err;
  logic [CW-1:0]   x_c, y_c;
  logic [VW-1:0]   wdata;
  logic [IW-1:0]   waddr1, waddr2;

  // Test path.
  logic [CNW-1:0]  ne, kmax;
  logic            last_edge, last_k;
  logic [IW-1:0]   j_idx, raddr;
  logic [VW-1:0]   rdata1, rdata2;
  logic            out_free;
  proj_ctrl_t      ctrl;
  proj_stat_t      stat;

  // --------------------------------------------------------------------------
  // Loading. Coordinates are brought to COORD_BITS by sign extension or by
  // dropping upper bits. A vertex beyond capacity is dropped and flagged.
  // --------------------------------------------------------------------------
  assign acc   = in_valid && !in_stall;
  assign full1 = (cnt1_r == CNW'(MAX_CORNERS));
  assign full2 = (cnt2_r == CNW'(MAX_CORNERS));
  assign we1   = acc && !in_data.polygon_select && !full1;
  assign we2   = acc && in_data.polygon_select && !full2;
  assign x_c   = CW'(in_data.vertex_x);
  assign y_c   = CW'(in_data.vertex_y);
  assign wdata = {y_c, x_c};
  assign waddr1 = cnt1_r[IW-1:0];
  assign waddr2 = cnt2_r[IW-1:0];

  // Counts and overflow as they stand once the accepted vertex is taken in.
  assign cnt1_ld  = we1 ? cnt1_r + CNW'(1) : cnt1_r;
  assign cnt2_ld  = we2 ? cnt2_r + CNW'(1) : cnt2_r;
  assign ovf_ld   = ovf_r || (acc && (in_data.polygon_select ? full2 : full1));
  assign load_err = ovf_ld || (cnt1_ld == '0) || (cnt2_ld == '0);

  // --------------------------------------------------------------------------
  // Axis and projection indexing. The edge from the last vertex wraps to the
  // first. Projection runs over the longer polygon; the shorter one's
  // indices past its count are masked out in the projection unit.
  // --------------------------------------------------------------------------
  assign ne        = side_r ? cnt2_r : cnt1_r;
  assign kmax      = (cnt1_r > cnt2_r) ? cnt1_r : cnt2_r;
  assign last_edge = ((CNW'(edge_r) + CNW'(1)) == ne);
  assign last_k    = ((CNW'(k_r) + CNW'(1)) == kmax);
  assign j_idx     = last_edge ? '0 : edge_r + IW'(1);

  always_comb begin
    case (state_r)
      S_EDGE_A: raddr = edge_r;
      S_EDGE_B: raddr = j_idx;
      default:  raddr = k_r;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  cpot_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_CORNERS)
  ) u_ram_first (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata1)
  );

  cpot_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_CORNERS)
  ) u_ram_second (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr2),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata2)
  );

  cpot_proj #(
    .COORD_BITS (COORD_BITS)
  ) u_proj (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .rdata_first  (rdata1),
    .rdata_second (rdata2),
    .stat         (stat)
  );

  // --------------------------------------------------------------------------
  // Next state. The test stops at the first axis that shows a gap.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (acc && in_data.end_of_pair) begin
          state_nxt = load_err ? S_FINISH : S_EDGE_A;
        end
      end
      S_EDGE_A: state_nxt = S_EDGE_B;
      S_EDGE_B: state_nxt = S_EDGE_C;
      S_EDGE_C: state_nxt = S_PROJ;
      S_PROJ: begin
        if (last_k) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          if (stat.gap || (last_edge && side_r)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_EDGE_A;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: counters, projection control and the result.
  // --------------------------------------------------------------------------
  always_comb begin
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    ovf_nxt       = ovf_r;
    side_nxt      = side_r;
    edge_nxt      = edge_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    ctrl           = '0;
    ctrl.side      = side_r;
    ctrl.in_first  = (CNW'(k_r) < cnt1_r);
    ctrl.in_second = (CNW'(k_r) < cnt2_r);
    ctrl.first_idx = (k_r == '0);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        cnt1_nxt = cnt1_ld;
        cnt2_nxt = cnt2_ld;
        ovf_nxt  = ovf_ld;
        side_nxt = 1'b0;
        edge_nxt = '0;
        k_nxt    = '0;
        if (acc && in_data.end_of_pair) begin
          res_nxt.collide    = 1'b0;
          res_nxt.load_error = load_err;
        end
      end
      S_EDGE_A: begin
        k_nxt = '0;
      end
      S_EDGE_B: begin
        ctrl.cap_vi = 1'b1;
      end
      S_EDGE_C: begin
        ctrl.load_axis = 1'b1;
      end
      S_PROJ: begin
        ctrl.issue = 1'b1;
        if (!last_k) begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          if (stat.gap) begin
            res_nxt.collide    = 1'b0;
            res_nxt.load_error = 1'b0;
          end else if (last_edge) begin
            if (side_r) begin
              res_nxt.collide    = 1'b1;
              res_nxt.load_error = 1'b0;
            end else begin
              side_nxt = 1'b1;
              edge_nxt = '0;
            end
          end else begin
            edge_nxt = edge_r + IW'(1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          cnt1_nxt      = '0;
          cnt2_nxt      = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        cnt1_nxt = '0;
        cnt2_nxt = '0;
        ovf_nxt  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ovf_r       <= 1'b0;
      side_r      <= 1'b0;
      edge_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      ovf_r       <= ovf_nxt;
      side_r      <= side_nxt;
      edge_r      <= edge_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Vertices are taken only while the sequencer is waiting for load items.
  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/convex_polygon_overlap_test_core_test.sv
// ----------------------------------------------------------------------------
// convex_polygon_overlap_test_core_test
// Self-checking bench for the separating axis overlap test. Vertex items are
// fed in random and directed pairs of convex and rough polygons. Each
// accepted item goes through a local model of the vertex stores and the axis
// tests, and every verdict that the block returns is checked in order against
// that model. Traffic is run under several mixes of sender gaps and receiver
// stalls, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module convex_polygon_overlap_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cpot_pkg::*;

  localparam int MAX_CORNERS    = 8;
  localparam int COORD_BITS     = 16;
  localparam int LATENCY_CYCLES = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 1750;
  localparam int MAX_REPORTED   = 10;
  localparam int SHAPE_SLOTS    = 12;

  // Order in which the vertices of the two polygons are fed to the block.
  typedef enum int {
    ORDER_FIRST_LEAD,
    ORDER_SECOND_LEAD,
    ORDER_MIXED
  } feed_order_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } corner_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  always #4 clk = ~clk;

  convex_polygon_overlap_test_core #(
    .MAX_CORNERS(MAX_CORNERS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // --------------------------------------------------------------------------
  // Local model of the block: the two vertex stores, their counts and the
  // sticky overflow flag, plus the queue of verdicts still owed by the block.
  // --------------------------------------------------------------------------
  corner_t   first_corners  [MAX_CORNERS];
  corner_t   second_corners [MAX_CORNERS];
  int        first_count    = 0;
  int        second_count   = 0;
  bit        overflow_flag  = 1'b0;
  out_item_t pending_verdicts [$];

  // Scratch polygons that the stimulus tasks build before feeding them.
  corner_t shape [2][SHAPE_SLOTS];
  int      shape_len [2];

  int items_sent       = 0;
  int verdicts_seen    = 0;
  int collisions_seen  = 0;
  int load_errors_seen = 0;
  int mismatches       = 0;
  int quiet_cycles     = 0;

  // Traffic shaping, set per phase by the test tasks.
  int idle_pct     = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;

  // Projection of one corner onto an axis. The widths here are far wider than
  // the 34 bits that a dot product can need, so nothing wraps.
  function automatic longint corner_dot(corner_t c, longint ax, longint ay);
    return longint'(c.x) * ax + longint'(c.y) * ay;
  endfunction

  // Smallest and largest projection of every stored vertex of one polygon.
  function automatic void interval_on_axis(bit second, longint ax, longint ay,
                                           output longint lo, output longint hi);
    int     n;
    longint p;
    n  = second ? second_count : first_count;
    lo = 0;
    hi = 0;
    for (int i = 0; i < n; i++) begin
      p = corner_dot(second ? second_corners[i] : first_corners[i], ax, ay);
      if (i == 0) begin
        lo = p;
        hi = p;
      end else begin
        if (p < lo) lo = p;
        if (p > hi) hi = p;
      end
    end
  endfunction

  // True if the normal of some edge of the chosen polygon parts the two
  // intervals. The last vertex closes back onto the first; an edge between
  // two equal vertices gives the zero axis, which can never part anything.
  function automatic bit edges_separate(bit second);
    int      n;
    int      j;
    corner_t a;
    corner_t b;
    longint  ax, ay, lo1, hi1, lo2, hi2;
    n = second ? second_count : first_count;
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      a  = second ? second_corners[i] : first_corners[i];
      b  = second ? second_corners[j] : first_corners[j];
      ax = -(longint'(b.y) - longint'(a.y));
      ay = longint'(b.x) - longint'(a.x);
      interval_on_axis(1'b0, ax, ay, lo1, hi1);
      interval_on_axis(1'b1, ax, ay, lo2, hi2);
      if (hi1 < lo2 || hi2 < lo1) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Take one accepted vertex into the model. Returns 1 with the verdict when
  // the item closes the pair.
  function automatic bit absorb_vertex(in_item_t it, output out_item_t verdict);
    corner_t c;
    bit      err;
    c.x     = it.vertex_x;
    c.y     = it.vertex_y;
    verdict = '0;
    // A vertex beyond the capacity of its polygon is dropped, but remembered.
    if (it.polygon_select) begin
      if (second_count < MAX_CORNERS) begin
        second_corners[second_count] = c;
        second_count++;
      end else begin
        overflow_flag = 1'b1;
      end
    end else begin
      if (first_count < MAX_CORNERS) begin
        first_corners[first_count] = c;
        first_count++;
      end else begin
        overflow_flag = 1'b1;
      end
    end
    if (!it.end_of_pair) return 1'b0;
    // An empty polygon or an overflow skips the test altogether.
    err                = overflow_flag || first_count == 0 || second_count == 0;
    verdict.load_error = err;
    verdict.collide    = !err && !edges_separate(1'b0) && !edges_separate(1'b1);
    // Whatever the verdict, the next pair starts from empty stores.
    first_count   = 0;
    second_count  = 0;
    overflow_flag = 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t vertex_item(bit sel, int x, int y, bit last);
    in_item_t it;
    it.polygon_select = sel;
    it.vertex_x       = x[15:0];
    it.vertex_y       = y[15:0];
    it.end_of_pair    = last;
    return it;
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Corners on a circle at rising (or falling) angles give a convex polygon.
  // Now and then a corner repeats its predecessor to make a zero-length edge.
  function automatic void fill_convex(bit which, int n, int cx, int cy, int r);
    real step, a0, a, dir;
    step = 6.283185307179586 / n;
    a0   = $urandom_range(0, 62831) / 10000.0;
    dir  = $urandom_range(1) ? 1.0 : -1.0;
    for (int i = 0; i < n; i++) begin
      a = a0 + dir * step * (i + 0.8 * $urandom_range(0, 1000) / 1000.0);
      shape[which][i].x = 16'(clip16($rtoi(cx + r * $cos(a))));
      shape[which][i].y = 16'(clip16($rtoi(cy + r * $sin(a))));
      if (i > 0 && $urandom_range(11) == 0) shape[which][i] = shape[which][i-1];
    end
    shape_len[which] = n;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Each call may first leave the channel idle for a random number of
  // cycles, then offers the item and holds it until the block takes it. The
  // stall is sampled on the falling edge, where it is settled for the rising
  // edge that follows.
  // --------------------------------------------------------------------------
  task automatic send_vertex(input in_item_t it);
    out_item_t verdict;
    bit        taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
    if (absorb_vertex(it, verdict))
      pending_verdicts.insert(pending_verdicts.size(), verdict);
  endtask

  // Feed both scratch polygons, each in its own order, and flag the very last
  // vertex as the end of the pair.
  task automatic send_shapes(input feed_order_t order);
    int i0, i1, idx, total;
    bit pick;
    i0    = 0;
    i1    = 0;
    total = shape_len[0] + shape_len[1];
    while (i0 < shape_len[0] || i1 < shape_len[1]) begin
      if (i0 == shape_len[0]) pick = 1'b1;
      else if (i1 == shape_len[1]) pick = 1'b0;
      else begin
        case (order)
          ORDER_FIRST_LEAD:  pick = 1'b0;
          ORDER_SECOND_LEAD: pick = 1'b1;
          default:           pick = $urandom_range(1);
        endcase
      end
      idx = pick ? i1 : i0;
      send_vertex(vertex_item(pick, shape[pick][idx].x, shape[pick][idx].y,
                              i0 + i1 + 1 == total));
      if (pick) i1++;
      else i0++;
    end
  endtask

  // Drop valid, wait until every verdict is back, then give the block time to
  // finish any work that owes no verdict.
  task automatic let_block_settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  // A well-formed pair: two convex polygons whose centres lie between well
  // apart and deeply overlapping, at tiny, moderate or near-full scale.
  task automatic random_overlap_pair();
    int  rmax, r0, r1, n0, n1, span, cx0, cy0, cx1, cy1;
    real ang, reach;
    case ($urandom_range(2))
      0:       rmax = 24;
      1:       rmax = 2000;
      default: rmax = 15000;
    endcase
    r0    = $urandom_range(1, rmax);
    r1    = $urandom_range(1, rmax);
    n0    = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, MAX_CORNERS);
    n1    = ($urandom_range(7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, MAX_CORNERS);
    span  = 32767 - rmax;
    cx0   = int'($urandom_range(0, 2 * span)) - span;
    cy0   = int'($urandom_range(0, 2 * span)) - span;
    ang   = $urandom_range(0, 62831) / 10000.0;
    reach = (r0 + r1) * ($urandom_range(20, 160) / 100.0);
    cx1   = cx0 + $rtoi(reach * $cos(ang));
    cy1   = cy0 + $rtoi(reach * $sin(ang));
    fill_convex(1'b0, n0, cx0, cy0, r0);
    fill_convex(1'b1, n1, cx1, cy1, r1);
    send_shapes(feed_order_t'($urandom_range(2)));
  endtask

  // A rough pair: raw random corners over the full field or a narrow patch,
  // with empty and over-full polygons among them.
  task automatic random_rough_pair();
    int n [2];
    bit narrow;
    n[0]   = $urandom_range(0, SHAPE_SLOTS - 2);
    n[1]   = $urandom_range(0, SHAPE_SLOTS - 2);
    if (n[0] + n[1] == 0) n[0] = 1;
    narrow = ($urandom_range(3) == 0);
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < n[s]; i++) begin
        shape[s][i].x = narrow ? 16'(int'($urandom_range(0, 63)) - 32) : 16'($urandom);
        shape[s][i].y = narrow ? 16'(int'($urandom_range(0, 63)) - 32) : 16'($urandom);
      end
      shape_len[s] = n[s];
    end
    send_shapes(feed_order_t'($urandom_range(2)));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // A pair that ends while one polygon is still empty, from either side.
  task automatic test_empty_polygon();
    send_vertex(vertex_item(1'b0, 5, -5, 1'b1));
    send_vertex(vertex_item(1'b1, -80, 48, 1'b1));
  endtask

  // Nine vertices for the first polygon: the ninth is dropped and the pair
  // must come back as a load error.
  task automatic test_vertex_overflow();
    for (int i = 0; i < MAX_CORNERS + 1; i++)
      send_vertex(vertex_item(1'b0, i * 16, i * i, 1'b0));
    send_vertex(vertex_item(1'b1, 7, 7, 1'b1));
  endtask

  // A triangle spanning the whole coordinate range against a lone corner
  // vertex: widest edges, largest products, and a single-vertex polygon.
  task automatic test_extreme_coordinates();
    send_vertex(vertex_item(1'b0, -32768, -32768, 1'b0));
    send_vertex(vertex_item(1'b0, 32767, -32768, 1'b0));
    send_vertex(vertex_item(1'b0, 32767, 32767, 1'b0));
    send_vertex(vertex_item(1'b1, -32768, 32767, 1'b1));
  endtask

  // Two repeated vertices against a point on top of them: every axis is
  // zero, so no gap can ever be found.
  task automatic test_degenerate_edges();
    send_vertex(vertex_item(1'b0, -300, 1200, 1'b0));
    send_vertex(vertex_item(1'b0, -300, 1200, 1'b0));
    send_vertex(vertex_item(1'b1, -300, 1200, 1'b1));
  endtask

  // Two triangles that share one corner: touching counts as a collision.
  task automatic test_touching_triangles();
    send_vertex(vertex_item(1'b0, 0, 0, 1'b0));
    send_vertex(vertex_item(1'b0, 160, 0, 1'b0));
    send_vertex(vertex_item(1'b0, 0, 160, 1'b0));
    send_vertex(vertex_item(1'b1, 160, 0, 1'b0));
    send_vertex(vertex_item(1'b1, 320, 0, 1'b0));
    send_vertex(vertex_item(1'b1, 160, 160, 1'b1));
  endtask

  // The receiver holds off for a long stretch while pairs keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_receiver_hold_off();
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    repeat (8) random_overlap_pair();
  endtask

  // Random pairs under each traffic mix in turn; between mixes the sender
  // pauses until every verdict is back.
  task automatic test_random_traffic();
    int idle_mix  [4] = '{0, 53, 0, 38};
    int stall_mix [4] = '{0, 0, 53, 38};
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      phase_end = items_sent + (ITEM_TARGET - items_sent) / (4 - p);
      while (items_sent < phase_end) begin
        if ($urandom_range(99) < 80) random_overlap_pair();
        else random_rough_pair();
      end
      let_block_settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Stalls at the rate of the current mix, or throughout a hold-off
  // that it counts down itself.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("MISMATCH %s: collide exp %0b got %0b, load_error exp %0b got %0b",
               what, want.collide, got.collide, want.load_error, got.load_error);
  endfunction

  // Every accepted verdict is compared with the oldest one the model expects.
  always @(posedge clk) begin : check_verdicts
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        note_mismatch("verdict with none expected", '0, out_data);
      end else begin
        want = pending_verdicts.pop_front();
        if (want.collide) collisions_seen++;
        if (want.load_error) load_errors_seen++;
        if (out_data.collide !== want.collide || out_data.load_error !== want.load_error)
          note_mismatch("verdict", want, out_data);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, pending_verdicts.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_polygon();
    test_vertex_overflow();
    test_extreme_coordinates();
    test_degenerate_edges();
    test_touching_triangles();
    let_block_settle();

    test_receiver_hold_off();
    let_block_settle();

    test_random_traffic();

    $display("Sent %0d vertex items; %0d verdicts checked, %0d collisions, %0d load errors.",
             items_sent, verdicts_seen, collisions_seen, load_errors_seen);
    $display("Traffic mixes: free flow, sender gaps, receiver stalls, both, %s %0d-cycle hold-off.",
             "and a", HOLD_CYCLES);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d verdicts never arrived",
               mismatches, pending_verdicts.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
